// ===== src/keyboard_scancode_to_char_fifo_assert.svh =====
// Assertion macros for the keyboard scancode decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef KEYBOARD_SCANCODE_TO_CHAR_FIFO_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_CHAR_FIFO_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define KBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbd assertion failed");

// Next-cycle implication, disabled during reset
`define KBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbd assertion failed");

`endif

// ===== src/kbd_pkg.sv =====
// Shared types, codes and key tables for the keyboard scancode decoder.
// No dependencies.
package kbd_pkg;

    // Request function codes
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Scancode set 1 codes
    localparam logic [7:0] SC_PREFIX_EXT = 8'hE0;
    localparam logic [6:0] SC_LSHIFT     = 7'h2A;
    localparam logic [6:0] SC_RSHIFT     = 7'h36;
    localparam logic [6:0] SC_CAPS       = 7'h3A;
    localparam logic [6:0] SC_UP         = 7'h48;
    localparam logic [6:0] SC_DOWN       = 7'h50;
    localparam logic [6:0] SC_LEFT       = 7'h4B;
    localparam logic [6:0] SC_RIGHT      = 7'h4D;
    localparam logic [6:0] SC_TABLE_LEN  = 7'd58;

    // Characters produced for the arrow keys, plus the no-character code and the lowercase letter bounds
    localparam logic [7:0] CH_UP    = 8'h80;
    localparam logic [7:0] CH_DOWN  = 8'h81;
    localparam logic [7:0] CH_LEFT  = 8'h82;
    localparam logic [7:0] CH_RIGHT = 8'h83;
    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    // Decoder to FIFO push request
    typedef struct packed {
        logic       push;
        logic [7:0] ch;
    } kbd_push_t;

    // Unshifted key table
    function automatic logic [7:0] plain_char(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd1:  c = 8'h1B; 6'd2:  c = 8'h31; 6'd3:  c = 8'h32; 6'd4:  c = 8'h33;
            6'd5:  c = 8'h34; 6'd6:  c = 8'h35; 6'd7:  c = 8'h36; 6'd8:  c = 8'h37;
            6'd9:  c = 8'h38; 6'd10: c = 8'h39; 6'd11: c = 8'h30; 6'd12: c = 8'h2D;
            6'd13: c = 8'h3D; 6'd14: c = 8'h08; 6'd15: c = 8'h09; 6'd16: c = 8'h71;
            6'd17: c = 8'h77; 6'd18: c = 8'h65; 6'd19: c = 8'h72; 6'd20: c = 8'h74;
            6'd21: c = 8'h79; 6'd22: c = 8'h75; 6'd23: c = 8'h69; 6'd24: c = 8'h6F;
            6'd25: c = 8'h70; 6'd26: c = 8'h5B; 6'd27: c = 8'h5D; 6'd28: c = 8'h0A;
            6'd30: c = 8'h61; 6'd31: c = 8'h73; 6'd32: c = 8'h64; 6'd33: c = 8'h66;
            6'd34: c = 8'h67; 6'd35: c = 8'h68; 6'd36: c = 8'h6A; 6'd37: c = 8'h6B;
            6'd38: c = 8'h6C; 6'd39: c = 8'h3B; 6'd40: c = 8'h27; 6'd41: c = 8'h60;
            6'd43: c = 8'h5C; 6'd44: c = 8'h7A; 6'd45: c = 8'h78; 6'd46: c = 8'h63;
            6'd47: c = 8'h76; 6'd48: c = 8'h62; 6'd49: c = 8'h6E; 6'd50: c = 8'h6D;
            6'd51: c = 8'h2C; 6'd52: c = 8'h2E; 6'd53: c = 8'h2F; 6'd55: c = 8'h2A;
            6'd57: c = 8'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    // Shifted key table
    function automatic logic [7:0] shifted_char(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd1:  c = 8'h1B; 6'd2:  c = 8'h21; 6'd3:  c = 8'h40; 6'd4:  c = 8'h23;
            6'd5:  c = 8'h24; 6'd6:  c = 8'h25; 6'd7:  c = 8'h5E; 6'd8:  c = 8'h26;
            6'd9:  c = 8'h2A; 6'd10: c = 8'h28; 6'd11: c = 8'h29; 6'd12: c = 8'h5F;
            6'd13: c = 8'h2B; 6'd14: c = 8'h08; 6'd15: c = 8'h09; 6'd16: c = 8'h51;
            6'd17: c = 8'h57; 6'd18: c = 8'h45; 6'd19: c = 8'h52; 6'd20: c = 8'h54;
            6'd21: c = 8'h59; 6'd22: c = 8'h55; 6'd23: c = 8'h49; 6'd24: c = 8'h4F;
            6'd25: c = 8'h50; 6'd26: c = 8'h7B; 6'd27: c = 8'h7D; 6'd28: c = 8'h0A;
            6'd30: c = 8'h41; 6'd31: c = 8'h53; 6'd32: c = 8'h44; 6'd33: c = 8'h46;
            6'd34: c = 8'h47; 6'd35: c = 8'h48; 6'd36: c = 8'h4A; 6'd37: c = 8'h4B;
            6'd38: c = 8'h4C; 6'd39: c = 8'h3A; 6'd40: c = 8'h22; 6'd41: c = 8'h7E;
            6'd43: c = 8'h7C; 6'd44: c = 8'h5A; 6'd45: c = 8'h58; 6'd46: c = 8'h43;
            6'd47: c = 8'h56; 6'd48: c = 8'h42; 6'd49: c = 8'h4E; 6'd50: c = 8'h4D;
            6'd51: c = 8'h3C; 6'd52: c = 8'h3E; 6'd53: c = 8'h3F; 6'd55: c = 8'h2A;
            6'd57: c = 8'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== src/kbd_if.sv =====
// Valid/ready stream interfaces for the keyboard scancode decoder.
// Request channel carries func and scan_byte; response channel carries the character.
interface kbd_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] scan_byte;

    modport source (output valid, output func, output scan_byte, input ready);
    modport sink   (input valid, input func, input scan_byte, output ready);
endinterface

interface kbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       was_empty;

    modport source (output valid, output char_out, output was_empty, input ready);
    modport sink   (input valid, input char_out, input was_empty, output ready);
endinterface

// ===== src/kbd_decoder.sv =====
// Scancode decoder: shift, caps-lock and extended-prefix flags plus key tables.
// Depends on kbd_pkg.
module kbd_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        scan_byte,
    output kbd_pkg::kbd_push_t push_req
);

    logic shift_reg, shift_next;
    logic caps_reg, caps_next;
    logic prefix_reg, prefix_next;
    logic [7:0] lo_ch;
    logic [7:0] hi_ch;
    logic       upper;
    logic [7:0] key_ch;

    // Table lookup for ordinary make codes
    always_comb
    begin
        lo_ch  = kbd_pkg::plain_char(scan_byte[5:0]);
        hi_ch  = kbd_pkg::shifted_char(scan_byte[5:0]);
        if (lo_ch >= kbd_pkg::CH_LOW_A && lo_ch <= kbd_pkg::CH_LOW_Z)
            upper = shift_reg ^ caps_reg;
        else
            upper = shift_reg;
        key_ch = upper ? hi_ch : lo_ch;
    end

    // Flag update and push decision
    always_comb
    begin
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        prefix_next   = prefix_reg;
        push_req.push = 1'b0;
        push_req.ch   = key_ch;
        if (take)
        begin
            if (scan_byte == kbd_pkg::SC_PREFIX_EXT)
                prefix_next = 1'b1;
            else if (prefix_reg)
            begin
                // extended byte: only arrow makes produce a character
                prefix_next = 1'b0;
                if (!scan_byte[7])
                begin
                    push_req.push = 1'b1;
                    case (scan_byte[6:0])
                        kbd_pkg::SC_UP:    push_req.ch = kbd_pkg::CH_UP;
                        kbd_pkg::SC_DOWN:  push_req.ch = kbd_pkg::CH_DOWN;
                        kbd_pkg::SC_LEFT:  push_req.ch = kbd_pkg::CH_LEFT;
                        kbd_pkg::SC_RIGHT: push_req.ch = kbd_pkg::CH_RIGHT;
                        default:           push_req.push = 1'b0;
                    endcase
                end
            end
            else if (scan_byte[7])
            begin
                // break: only the shift keys matter
                if (scan_byte[6:0] == kbd_pkg::SC_LSHIFT ||
                    scan_byte[6:0] == kbd_pkg::SC_RSHIFT)
                    shift_next = 1'b0;
            end
            else if (scan_byte[6:0] == kbd_pkg::SC_LSHIFT ||
                     scan_byte[6:0] == kbd_pkg::SC_RSHIFT)
                shift_next = 1'b1;
            else if (scan_byte[6:0] == kbd_pkg::SC_CAPS)
                caps_next = !caps_reg;
            else if (scan_byte[6:0] < kbd_pkg::SC_TABLE_LEN)
                push_req.push = (key_ch != kbd_pkg::CH_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else
        begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ===== src/kbd_fifo.sv =====
// Character ring buffer in a synchronous RAM with a registered read.
// Depends on kbd_pkg. Holds FIFO_DEPTH-1 characters.
module kbd_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kbd_pkg::kbd_push_t push_req,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         rd_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_adv;
    logic [AW-1:0] rd_adv;
    logic [7:0]    rd_data_reg;
    logic          full;
    logic          wr_en;
    logic          rd_en;

    // Pointer arithmetic with wrap at the depth
    always_comb
    begin
        wr_adv = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        rd_adv = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        empty  = (wr_ptr_reg == rd_ptr_reg);
        full   = (wr_adv == rd_ptr_reg);
        wr_en  = push_req.push && !full;
        rd_en  = pop && !empty;
        wr_ptr_next = wr_en ? wr_adv : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_adv : rd_ptr_reg;
    end

    // One item is either a push or a pop, so the same entry is never
    // written and read in one cycle; no bypass is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= push_req.ch;
        if (rd_en)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/keyboard_scancode_to_char_fifo.sv =====
// Keyboard scancode (set 1) to character decoder with a ring buffer.
// Depends on kbd_pkg, kbd_if, kbd_decoder, kbd_fifo and the assertion header.
//
// Usage:
//   req channel: func=0 delivers one scancode byte (no response word),
//                func=1 requests one character (one response word).
//   rsp channel: char_out is the oldest buffered character (ASCII or
//                0x80..0x83 for arrows), or 0 with was_empty=1 when empty.
//   Path: an accepted read request goes through the RAM read stage, then
//   the output register, to give its response word.
//   Throughput: one request word per cycle unless rsp stalls; scancode bytes and
//   reads mix freely. The single RAM port pair (one write, one read) sets this.
//   Characters that arrive while FIFO_DEPTH-1 are held are dropped.
//   Reset clears flags and pointers; the RAM needs no clearing.
//   When rsp stalls, the output register and the RAM-read stage fill,
//   then req.ready drops until rsp.ready returns.
module keyboard_scancode_to_char_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    kbd_req_if.sink   req,
    kbd_rsp_if.source rsp
);

    logic               acc;
    logic               s1_adv;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_empty_reg;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_char_reg;
    logic               out_empty_reg;
    logic               fifo_empty;
    logic [7:0]         fifo_rd_data;
    kbd_pkg::kbd_push_t push_req;

    // Handshake and stage advance
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign acc       = req.valid && req.ready;

    kbd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (acc && !req.func),
        .scan_byte (req.scan_byte),
        .push_req  (push_req)
    );

    kbd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (push_req),
        .pop      (acc && req.func),
        .empty    (fifo_empty),
        .rd_data  (fifo_rd_data)
    );

    // Stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc && req.func)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (acc && req.func)
            s1_empty_reg <= fifo_empty;
        if (s1_adv)
        begin
            out_char_reg  <= s1_empty_reg ? kbd_pkg::CH_NONE : fifo_rd_data;
            out_empty_reg <= s1_empty_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.char_out  = out_char_reg;
    assign rsp.was_empty = out_empty_reg;

    // Checks
`include "keyboard_scancode_to_char_fifo_assert.svh"
    `KBD_ASSERT_NOW(a_ready_low_only_when_full, !req.ready,
                    s1_valid_reg && out_valid_reg && !rsp.ready)
    `KBD_ASSERT_NOW(a_empty_word_zero, rsp.valid && rsp.was_empty,
                    rsp.char_out == kbd_pkg::CH_NONE)
    `KBD_ASSERT_NEXT(a_read_enters_stage, req.valid && req.ready && req.func,
                     s1_valid_reg)

endmodule

// ===== dv/keyboard_scancode_to_char_fifo_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the keyboard scancode decoder: watches the request and response
// channels, predicts each response word and compares it. Depends on kbd_pkg and kbd_if.
module keyboard_scancode_to_char_fifo_checker #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    kbd_req_if   req,
    kbd_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   read_count,
    output int   empty_count,
    output int   drop_count
);

    localparam int   REPORT_MAX = 10;
    localparam int   KEY_COUNT  = 58;

    // Key tables, entry 0 in the top byte
    localparam logic [KEY_COUNT*8-1:0] PLAIN_KEYS = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };
    localparam logic [KEY_COUNT*8-1:0] SHIFTED_KEYS = {
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       empty;
    } read_word_t;

    // Predicted decoder state and buffer contents
    read_word_t char_expect_q[$];
    logic [7:0] typed_chars[$];
    bit         shift_down;
    bit         caps_lock;
    bit         ext_armed;

    function automatic logic [7:0] key_entry(input logic [KEY_COUNT*8-1:0] tbl,
                                             input logic [6:0] idx);
        return tbl[(KEY_COUNT - 1 - idx)*8 +: 8];
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Buffer holds FIFO_DEPTH-1 characters; the rest are lost
    task automatic queue_char(input logic [7:0] ch);
        if (typed_chars.size() < FIFO_DEPTH - 1)
            typed_chars.push_back(ch);
        else
            drop_count++;
    endtask

    task automatic predict_scancode(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        logic       upper;
        if (b == kbd_pkg::SC_PREFIX_EXT)
        begin
            ext_armed = 1'b1;
        end
        else if (ext_armed)
        begin
            // extended byte: only arrow makes produce anything
            ext_armed = 1'b0;
            if (!b[7])
            begin
                if (b[6:0] == kbd_pkg::SC_UP)         queue_char(kbd_pkg::CH_UP);
                else if (b[6:0] == kbd_pkg::SC_DOWN)  queue_char(kbd_pkg::CH_DOWN);
                else if (b[6:0] == kbd_pkg::SC_LEFT)  queue_char(kbd_pkg::CH_LEFT);
                else if (b[6:0] == kbd_pkg::SC_RIGHT) queue_char(kbd_pkg::CH_RIGHT);
            end
        end
        else if (b[7])
        begin
            if (b[6:0] == kbd_pkg::SC_LSHIFT || b[6:0] == kbd_pkg::SC_RSHIFT)
                shift_down = 1'b0;
        end
        else if (b[6:0] == kbd_pkg::SC_LSHIFT || b[6:0] == kbd_pkg::SC_RSHIFT)
        begin
            shift_down = 1'b1;
        end
        else if (b[6:0] == kbd_pkg::SC_CAPS)
        begin
            caps_lock = !caps_lock;
        end
        else if (b[6:0] < kbd_pkg::SC_TABLE_LEN)
        begin
            lo = key_entry(PLAIN_KEYS, b[6:0]);
            hi = key_entry(SHIFTED_KEYS, b[6:0]);
            // caps lock only matters for letters
            if (lo >= kbd_pkg::CH_LOW_A && lo <= kbd_pkg::CH_LOW_Z)
                upper = shift_down ^ caps_lock;
            else
                upper = shift_down;
            if ((upper ? hi : lo) != kbd_pkg::CH_NONE)
                queue_char(upper ? hi : lo);
        end
    endtask

    // Predict on each accepted request word, compare each accepted response word
    always @(posedge clk or negedge rst_n)
    begin
        read_word_t got;
        read_word_t want;
        if (!rst_n)
        begin
            char_expect_q.delete();
            typed_chars.delete();
            shift_down = 1'b0;
            caps_lock  = 1'b0;
            ext_armed  = 1'b0;
            pending    = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                if (req.func == kbd_pkg::FUNC_READ)
                begin
                    read_count++;
                    if (typed_chars.size() == 0)
                    begin
                        want.ch    = kbd_pkg::CH_NONE;
                        want.empty = 1'b1;
                        empty_count++;
                    end
                    else
                    begin
                        want.ch    = typed_chars.pop_front();
                        want.empty = 1'b0;
                    end
                    char_expect_q.push_back(want);
                end
                else
                begin
                    predict_scancode(req.scan_byte);
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                got.ch    = rsp.char_out;
                got.empty = rsp.was_empty;
                if (char_expect_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected word char_out=%02h was_empty=%0b",
                                           got.ch, got.empty));
                end
                else
                begin
                    want = char_expect_q.pop_front();
                    if (got.ch !== want.ch || got.empty !== want.empty)
                        note_failure($sformatf(
                            "char_out exp %02h got %02h, was_empty exp %0b got %0b",
                            want.ch, got.ch, want.empty, got.empty));
                end
            end
            pending = char_expect_q.size();
        end
    end

endmodule

// ===== dv/keyboard_scancode_to_char_fifo_tb.sv =====
`timescale 1ns / 1ps
// Top of the keyboard scancode decoder testbench: clock, reset, request stimulus
// and response backpressure. Depends on kbd_pkg, kbd_if, the DUT and the checker.
module keyboard_scancode_to_char_fifo_tb;

    localparam int   DEPTH        = 256;
    localparam int   FILL_WORDS   = DEPTH + 8;
    localparam int   RANDOM_WORDS = 1400;
    localparam int   BLOCK_WORDS  = 100;

    // A few plain keys and unmapped codes used by the directed part
    localparam logic [7:0] KEY_A     = 8'h1E;
    localparam logic [7:0] KEY_1     = 8'h02;
    localparam logic [7:0] KEY_SPACE = 8'h39;
    localparam logic [7:0] KEY_NONE  = 8'h00;
    localparam logic [7:0] KEY_HIGH  = 8'hFF;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   rsp_stall_pct;
    int   scan_count;
    int   fail_count;
    int   pending;
    int   read_count;
    int   empty_count;
    int   drop_count;

    kbd_req_if req_bus ();
    kbd_rsp_if rsp_bus ();

    keyboard_scancode_to_char_fifo #(
        .FIFO_DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    keyboard_scancode_to_char_fifo_checker #(
        .FIFO_DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .fail_count  (fail_count),
        .pending     (pending),
        .read_count  (read_count),
        .empty_count (empty_count),
        .drop_count  (drop_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d response words outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Response backpressure, redrawn every cycle
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Offer one request word, with random idle cycles ahead of it
    task automatic send_word(input logic f, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.func      <= f;
        req_bus.scan_byte <= b;
        do @(posedge clk); while (!req_bus.ready);
        @(negedge clk);
        if (f == kbd_pkg::FUNC_SCAN)
            scan_count++;
    endtask

    initial
    begin
        logic [8:0] directed_q[$];
        logic [7:0] key;
        logic       brk;
        int         sent;
        int         blk;
        int         read_pct;
        int         pick;

        req_bus.valid     = 1'b0;
        req_bus.func      = kbd_pkg::FUNC_SCAN;
        req_bus.scan_byte = 8'h00;
        rst_n             = 1'b0;
        send_idle_pct     = 0;
        rsp_stall_pct     = 0;
        scan_count        = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty read, shift and caps on letters and digits, prefix cases,
        // unmapped and ignored codes, then drain past empty
        directed_q = '{
            {kbd_pkg::FUNC_READ, 8'h00},
            {kbd_pkg::FUNC_SCAN, KEY_A},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_LSHIFT},
            {kbd_pkg::FUNC_SCAN, KEY_A},
            {kbd_pkg::FUNC_SCAN, KEY_1},
            {kbd_pkg::FUNC_SCAN, 1'b1, kbd_pkg::SC_LSHIFT},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_CAPS},
            {kbd_pkg::FUNC_SCAN, KEY_A},
            {kbd_pkg::FUNC_SCAN, KEY_1},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_RSHIFT},
            {kbd_pkg::FUNC_SCAN, KEY_A},
            {kbd_pkg::FUNC_SCAN, 1'b1, kbd_pkg::SC_RSHIFT},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_CAPS},
            {kbd_pkg::FUNC_SCAN, kbd_pkg::SC_PREFIX_EXT},
            {kbd_pkg::FUNC_SCAN, kbd_pkg::SC_PREFIX_EXT},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_UP},
            {kbd_pkg::FUNC_SCAN, kbd_pkg::SC_PREFIX_EXT},
            {kbd_pkg::FUNC_SCAN, 1'b1, kbd_pkg::SC_UP},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_DOWN},
            {kbd_pkg::FUNC_SCAN, kbd_pkg::SC_PREFIX_EXT},
            {kbd_pkg::FUNC_SCAN, 1'b0, kbd_pkg::SC_RIGHT},
            {kbd_pkg::FUNC_SCAN, kbd_pkg::SC_PREFIX_EXT},
            {kbd_pkg::FUNC_SCAN, KEY_A},
            {kbd_pkg::FUNC_SCAN, KEY_NONE},
            {kbd_pkg::FUNC_SCAN, KEY_HIGH},
            {kbd_pkg::FUNC_SCAN, KEY_SPACE}
        };
        repeat (10) directed_q.push_back({kbd_pkg::FUNC_READ, 8'hFF});
        foreach (directed_q[i])
            send_word(directed_q[i][8], directed_q[i][7:0]);

        // Hold off until every read has been answered
        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        // Type past capacity so the buffer fills and drops characters
        repeat (FILL_WORDS) send_word(kbd_pkg::FUNC_SCAN, KEY_A);

        // Random: mostly typing with random content, some noise; read rate and
        // idling change per block so the buffer both fills and runs dry
        sent = 0;
        blk  = 0;
        while (sent < RANDOM_WORDS)
        begin
            case (blk % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
                default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
            endcase
            case ($urandom_range(2))
                0: read_pct = 4;
                1: read_pct = 30;
                default: read_pct = 60;
            endcase
            while (sent < (blk + 1) * BLOCK_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < read_pct)
                begin
                    send_word(kbd_pkg::FUNC_READ, 8'($urandom_range(255)));
                    sent++;
                end
                else
                begin
                    pick = $urandom_range(99);
                    brk  = 1'($urandom_range(1));
                    if (pick < 55)
                        key = 8'($urandom_range(57));
                    else if (pick < 63)
                        key = {brk, ($urandom_range(1) ? kbd_pkg::SC_LSHIFT
                                                       : kbd_pkg::SC_RSHIFT)};
                    else if (pick < 67)
                        key = {1'b0, kbd_pkg::SC_CAPS};
                    else if (pick < 88)
                        key = 8'($urandom_range(255)) | 8'h80;
                    else
                        key = 8'($urandom_range(255));
                    if (pick >= 67 && pick < 80)
                    begin
                        // extended sequence: mostly arrow makes or breaks
                        send_word(kbd_pkg::FUNC_SCAN, kbd_pkg::SC_PREFIX_EXT);
                        sent++;
                        if ($urandom_range(4) != 0)
                        begin
                            case ($urandom_range(3))
                                0: key = {brk, kbd_pkg::SC_UP};
                                1: key = {brk, kbd_pkg::SC_DOWN};
                                2: key = {brk, kbd_pkg::SC_LEFT};
                                default: key = {brk, kbd_pkg::SC_RIGHT};
                            endcase
                        end
                    end
                    send_word(kbd_pkg::FUNC_SCAN, key);
                    sent++;
                end
            end
            blk++;
        end

        // Drain
        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Covered %0d scancode words and %0d reads (%0d on an empty buffer).",
                 scan_count, read_count, empty_count);
        $display("%0d characters were lost on a full %0d-slot buffer; %0d failures.",
                 drop_count, DEPTH - 1, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== keyboard_scancode_to_char_fifo.f =====
+incdir+src
src/kbd_pkg.sv
src/kbd_if.sv
src/kbd_decoder.sv
src/kbd_fifo.sv
src/keyboard_scancode_to_char_fifo.sv
dv/keyboard_scancode_to_char_fifo_checker.sv
dv/keyboard_scancode_to_char_fifo_tb.sv
